FILE: sv/banked_register_file_unit_defines.svh
// Assertion macros for the banked register file unit.
// Needs a clock i_clk and an active-low reset i_rst_n in the including scope.
`ifndef BANKED_REGISTER_FILE_UNIT_DEFINES_SVH
`define BANKED_REGISTER_FILE_UNIT_DEFINES_SVH

// Property that must hold at every clock edge outside reset
`define BRF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next edge
`define BRF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/brf_pkg.sv
// Shared types and constants of the banked register file unit.
// No dependencies; the other source files, apart from the assertion header, use it by scoped names.
`timescale 1ns / 1ps

package brf_pkg;

    // Storage geometry
    localparam int DATA_W     = 32;
    localparam int MODE_W     = 5;
    localparam int REG_W      = 4;
    localparam int FUNC_W     = 3;
    localparam int GP_DEPTH   = 31;
    localparam int SPSR_DEPTH = 5;
    localparam int GP_IDX_W   = $clog2(GP_DEPTH);
    localparam int SLOT_W     = $clog2(SPSR_DEPTH);

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_RD_REG  = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_WR_REG  = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_RD_UREG = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_WR_UREG = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_RD_CPSR = 3'd4;
    localparam logic [FUNC_W-1:0] FUNC_WR_CPSR = 3'd5;
    localparam logic [FUNC_W-1:0] FUNC_RD_SPSR = 3'd6;
    localparam logic [FUNC_W-1:0] FUNC_WR_SPSR = 3'd7;

    // Processor mode codes
    localparam logic [MODE_W-1:0] MODE_USR = 5'h10;
    localparam logic [MODE_W-1:0] MODE_FIQ = 5'h11;
    localparam logic [MODE_W-1:0] MODE_IRQ = 5'h12;
    localparam logic [MODE_W-1:0] MODE_SVC = 5'h13;
    localparam logic [MODE_W-1:0] MODE_ABT = 5'h17;
    localparam logic [MODE_W-1:0] MODE_UND = 5'h1B;
    localparam logic [MODE_W-1:0] MODE_SYS = 5'h1F;

    // Bank offsets added to the architectural register number
    localparam logic [GP_IDX_W-1:0] OFS_NONE = 5'd0;
    localparam logic [GP_IDX_W-1:0] OFS_SVC  = 5'd3;
    localparam logic [GP_IDX_W-1:0] OFS_ABT  = 5'd5;
    localparam logic [GP_IDX_W-1:0] OFS_UND  = 5'd7;
    localparam logic [GP_IDX_W-1:0] OFS_IRQ  = 5'd9;
    localparam logic [GP_IDX_W-1:0] OFS_FIQ  = 5'd16;

    // Saved status slots
    localparam logic [SLOT_W-1:0] SLOT_SVC = 3'd0;
    localparam logic [SLOT_W-1:0] SLOT_ABT = 3'd1;
    localparam logic [SLOT_W-1:0] SLOT_UND = 3'd2;
    localparam logic [SLOT_W-1:0] SLOT_IRQ = 3'd3;
    localparam logic [SLOT_W-1:0] SLOT_FIQ = 3'd4;

    // Source of the read data
    typedef enum logic [1:0] {
        RSEL_NONE,
        RSEL_GP,
        RSEL_CPSR,
        RSEL_SPSR
    } t_rsel;

    // Request beat
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REG_W-1:0]  reg_index;
        logic [DATA_W-1:0] write_data;
    } t_req;

    // Result beat
    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic [MODE_W-1:0] cur_mode;
        logic              has_saved_status;
        logic              privileged;
    } t_rsp;

    // Decoded access from the mapper to the storage
    typedef struct packed {
        logic [GP_IDX_W-1:0] gp_idx;
        logic                gp_we;
        logic [SLOT_W-1:0]   spsr_slot;
        logic                spsr_ok;
        logic                spsr_we;
        logic                cpsr_we;
        t_rsel               rsel;
    } t_acc;

endpackage

FILE: sv/banked_register_file_unit.sv
// Top level of the banked register file unit: request register, decode, storage,
// result register. Depends on brf_pkg, brf_map, brf_regs and the assertion header.
`timescale 1ns / 1ps
`include "banked_register_file_unit_defines.svh"

//  channel   | ports                     | handshake
//  ----------+---------------------------+------------------------------
//  request   | i_req (t_req)             | start high, busy low
//  result    | o_rsp (t_rsp)             | o_valid strobe, one cycle
//
//  One access per cycle: busy stays low, so a beat can be started every cycle.
//  A result goes from the request register through decode and storage into the
//  result register.
//  Accesses take effect in start order; a read sees every earlier write.
//  Synchronous reset clears all storage to zero (status word zero = unknown mode).
//  The receiver cannot stall; each result is shown for exactly one cycle.

module banked_register_file_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  brf_pkg::t_req i_req,
    output logic          o_valid,
    output brf_pkg::t_rsp o_rsp
);

    logic                         r_req_vld;
    brf_pkg::t_req                r_req;
    logic                         r_rsp_vld;
    brf_pkg::t_rsp                r_rsp;
    brf_pkg::t_rsp                n_rsp;
    brf_pkg::t_acc                w_acc;
    logic [brf_pkg::DATA_W-1:0]   w_rdata;
    logic [brf_pkg::DATA_W-1:0]   w_cpsr;
    logic [brf_pkg::MODE_W-1:0]   w_mode_after;

    assign busy = 1'b0;

    // Request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_vld <= 1'b0;
        end else begin
            r_req_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_req <= i_req;
        end
    end

    brf_map u_map (
        .i_vld  (r_req_vld),
        .i_func (r_req.func),
        .i_reg  (r_req.reg_index),
        .i_mode (w_cpsr[brf_pkg::MODE_W-1:0]),
        .o_acc  (w_acc)
    );

    brf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_acc   (w_acc),
        .i_wdata (r_req.write_data),
        .o_rdata (w_rdata),
        .o_cpsr  (w_cpsr)
    );

    // Result: mode after the access, flags derived from it
    always_comb begin
        w_mode_after = w_acc.cpsr_we ? r_req.write_data[brf_pkg::MODE_W-1:0]
                                     : w_cpsr[brf_pkg::MODE_W-1:0];
        n_rsp.read_data        = w_rdata;
        n_rsp.cur_mode         = w_mode_after;
        n_rsp.has_saved_status = (w_mode_after != brf_pkg::MODE_USR)
                                 && (w_mode_after != brf_pkg::MODE_SYS);
        n_rsp.privileged       = (w_mode_after != brf_pkg::MODE_USR);
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_vld <= 1'b0;
        end else begin
            r_rsp_vld <= r_req_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_req_vld) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_valid = r_rsp_vld;
    assign o_rsp   = r_rsp;

    // Every registered request yields exactly one result beat next cycle
    `BRF_ASSERT_NEXT(a_req_to_rsp, r_req_vld, r_rsp_vld, "request beat produced no result")
    `BRF_ASSERT_NEXT(a_no_rsp, !r_req_vld, !r_rsp_vld, "result beat without a request")
    // Reported mode is the one now held in the status word
    `BRF_ASSERT(a_mode_match, !r_rsp_vld || (r_rsp.cur_mode == w_cpsr[brf_pkg::MODE_W-1:0]),
        "reported mode differs from status word")
    // A mode with saved status is always privileged
    `BRF_ASSERT(a_flags, !r_rsp_vld || !r_rsp.has_saved_status || r_rsp.privileged,
        "saved status reported for unprivileged mode")
    // Write operations (odd codes) return zero data
    `BRF_ASSERT(a_wr_zero, !r_rsp_vld || !$past(r_req.func[0]) || (r_rsp.read_data == '0),
        "write operation returned nonzero data")

endmodule

FILE: sv/brf_map.sv
// Access decoder: maps operation, register number and mode to storage controls.
// Depends on brf_pkg.
`timescale 1ns / 1ps

module brf_map (
    input  logic                        i_vld,
    input  logic [brf_pkg::FUNC_W-1:0] i_func,
    input  logic [brf_pkg::REG_W-1:0]  i_reg,
    input  logic [brf_pkg::MODE_W-1:0] i_mode,
    output brf_pkg::t_acc               o_acc
);

    logic [brf_pkg::GP_IDX_W-1:0] w_ofs;
    logic [brf_pkg::GP_IDX_W-1:0] w_raw_idx;
    logic [brf_pkg::SLOT_W-1:0]   w_slot;
    logic                         w_slot_ok;
    logic                         w_banked;

    // Bank offset and saved-status slot per mode; unknown modes use the user bank
    always_comb begin
        w_ofs     = brf_pkg::OFS_NONE;
        w_slot    = brf_pkg::SLOT_SVC;
        w_slot_ok = 1'b0;
        case (i_mode)
            brf_pkg::MODE_SVC: begin
                w_ofs     = brf_pkg::OFS_SVC;
                w_slot    = brf_pkg::SLOT_SVC;
                w_slot_ok = 1'b1;
            end
            brf_pkg::MODE_ABT: begin
                w_ofs     = brf_pkg::OFS_ABT;
                w_slot    = brf_pkg::SLOT_ABT;
                w_slot_ok = 1'b1;
            end
            brf_pkg::MODE_UND: begin
                w_ofs     = brf_pkg::OFS_UND;
                w_slot    = brf_pkg::SLOT_UND;
                w_slot_ok = 1'b1;
            end
            brf_pkg::MODE_IRQ: begin
                w_ofs     = brf_pkg::OFS_IRQ;
                w_slot    = brf_pkg::SLOT_IRQ;
                w_slot_ok = 1'b1;
            end
            brf_pkg::MODE_FIQ: begin
                w_ofs     = brf_pkg::OFS_FIQ;
                w_slot    = brf_pkg::SLOT_FIQ;
                w_slot_ok = 1'b1;
            end
            default: begin
                w_ofs     = brf_pkg::OFS_NONE;
                w_slot    = brf_pkg::SLOT_SVC;
                w_slot_ok = 1'b0;
            end
        endcase
    end

    // r13/r14 always banked, r8..r12 only in FIQ mode
    always_comb begin
        w_raw_idx = {1'b0, i_reg};
        w_banked  = (i_reg inside {4'd13, 4'd14})
                    || ((i_reg inside {[4'd8:4'd12]}) && (i_mode == brf_pkg::MODE_FIQ));
    end

    // Storage controls per operation
    always_comb begin
        o_acc           = '0;
        o_acc.spsr_slot = w_slot;
        o_acc.spsr_ok   = w_slot_ok;
        o_acc.rsel      = brf_pkg::RSEL_NONE;
        case (i_func)
            brf_pkg::FUNC_RD_REG: begin
                o_acc.gp_idx = w_banked ? (w_raw_idx + w_ofs) : w_raw_idx;
                o_acc.rsel   = brf_pkg::RSEL_GP;
            end
            brf_pkg::FUNC_WR_REG: begin
                o_acc.gp_idx = w_banked ? (w_raw_idx + w_ofs) : w_raw_idx;
                o_acc.gp_we  = i_vld;
            end
            brf_pkg::FUNC_RD_UREG: begin
                o_acc.gp_idx = w_raw_idx;
                o_acc.rsel   = brf_pkg::RSEL_GP;
            end
            brf_pkg::FUNC_WR_UREG: begin
                o_acc.gp_idx = w_raw_idx;
                o_acc.gp_we  = i_vld;
            end
            brf_pkg::FUNC_RD_CPSR: begin
                o_acc.rsel = brf_pkg::RSEL_CPSR;
            end
            brf_pkg::FUNC_WR_CPSR: begin
                o_acc.cpsr_we = i_vld;
            end
            brf_pkg::FUNC_RD_SPSR: begin
                o_acc.rsel = brf_pkg::RSEL_SPSR;
            end
            brf_pkg::FUNC_WR_SPSR: begin
                o_acc.spsr_we = i_vld && w_slot_ok;
            end
            default: begin
                o_acc.rsel = brf_pkg::RSEL_NONE;
            end
        endcase
    end

endmodule

FILE: sv/brf_regs.sv
// Register storage: general bank entries, current status word, saved status words.
// Depends on brf_pkg; driven by the controls from brf_map.
`timescale 1ns / 1ps

module brf_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  brf_pkg::t_acc               i_acc,
    input  logic [brf_pkg::DATA_W-1:0] i_wdata,
    output logic [brf_pkg::DATA_W-1:0] o_rdata,
    output logic [brf_pkg::DATA_W-1:0] o_cpsr
);

    logic [brf_pkg::DATA_W-1:0] r_gp   [brf_pkg::GP_DEPTH];
    logic [brf_pkg::DATA_W-1:0] r_spsr [brf_pkg::SPSR_DEPTH];
    logic [brf_pkg::DATA_W-1:0] r_cpsr;

    // General entries, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < brf_pkg::GP_DEPTH; k++) begin
                r_gp[k] <= '0;
            end
        end else if (i_acc.gp_we) begin
            r_gp[i_acc.gp_idx] <= i_wdata;
        end
    end

    // Saved status words
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < brf_pkg::SPSR_DEPTH; k++) begin
                r_spsr[k] <= '0;
            end
        end else if (i_acc.spsr_we) begin
            r_spsr[i_acc.spsr_slot] <= i_wdata;
        end
    end

    // Current status word; reset leaves an unknown mode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cpsr <= '0;
        end else if (i_acc.cpsr_we) begin
            r_cpsr <= i_wdata;
        end
    end

    // Read data select
    always_comb begin
        case (i_acc.rsel)
            brf_pkg::RSEL_GP:   o_rdata = r_gp[i_acc.gp_idx];
            brf_pkg::RSEL_CPSR: o_rdata = r_cpsr;
            brf_pkg::RSEL_SPSR: o_rdata = i_acc.spsr_ok ? r_spsr[i_acc.spsr_slot] : '0;
            default:            o_rdata = '0;
        endcase
    end

    assign o_cpsr = r_cpsr;

endmodule
